// ===== rtl/dual_integral_image_assert.svh =====
// ---------------------------------------------------------------------------
// Dual integral image assertion macros
// Shared concurrent assertion forms, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef DUAL_INTEGRAL_IMAGE_ASSERT_SVH
`define DUAL_INTEGRAL_IMAGE_ASSERT_SVH

// Same-cycle implication: when cond holds, prop must hold in that cycle.
`define DII_ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("dual_integral_image: same-cycle check failed");

// Next-cycle implication: when cond holds, prop must hold in the next cycle.
`define DII_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("dual_integral_image: next-cycle check failed");

`endif

// ===== rtl/dii_pkg.sv =====
// ---------------------------------------------------------------------------
// Dual integral image package
// Widths, register indexes, scan flags and the saturating adder.
// ---------------------------------------------------------------------------
package dii_pkg;

  localparam int SUM_W       = 36;
  localparam int MAG_W       = 16;
  localparam int WGT_W       = 24;
  localparam int LEN_W       = 11;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int LEN_MIN     = 2;

  localparam int MAX_LINE_LENGTH_DEFAULT = 1024;
  localparam int MAX_LINE_COUNT_DEFAULT  = 1024;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_THRESHOLD   = 2'd0,
    CFG_LINE_LENGTH = 2'd1,
    CFG_LINE_COUNT  = 2'd2
  } cfg_index_t;

  // Position flags of the pixel being accepted.
  typedef struct packed {
    logic first_col;
    logic first_line;
    logic last_pix;
    logic frame_end;
  } scan_info_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

// ===== rtl/dual_integral_image.sv =====
// ---------------------------------------------------------------------------
// Dual integral image
// Two saturating summed-area tables over a raster-scanned pixel stream.
// ---------------------------------------------------------------------------
// Pixels enter on the pixel channel (pixel_valid / pixel_stall) in raster
// order, one edge magnitude and one point weight per transfer. Every pixel
// produces exactly one result transfer on the sum channel (sum_valid /
// sum_stall) carrying the thresholded magnitude integral, the weight
// integral and a frame_end flag on the last pixel of the frame.
// The block takes one pixel per cycle while pixel_stall is low. The transfer
// edge registers the pixel in the input stage together with the line buffer
// read at its column and the updated line running sums; when the output
// register is empty or taken, the stage adds the integral from the line
// above and loads the output register while writing the new value back to
// the line buffer.
// When the receiver stalls, the output register holds its result and the
// stage behind it keeps filling; pixel_stall rises only when both stages
// are occupied and the output is stalled.
// Reset clears the scan counters, the running sums, the stage valids and
// the threshold, and sets line length and count to 1024. The line buffers
// need no clearing because the first line of each frame ignores their data.
// Configuration writes are taken at once on config_write; index three is
// ignored.
// ---------------------------------------------------------------------------
module dual_integral_image import dii_pkg::*; #(
  parameter int MAX_LINE_LENGTH = MAX_LINE_LENGTH_DEFAULT,
  parameter int MAX_LINE_COUNT  = MAX_LINE_COUNT_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   config_write,
  input  logic [CFG_INDEX_W-1:0] config_index,
  input  logic [CFG_DATA_W-1:0]  config_data,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  logic [MAG_W-1:0]       edge_magnitude,
  input  logic [WGT_W-1:0]       point_weight,
  output logic                   sum_valid,
  input  logic                   sum_stall,
  output logic [SUM_W-1:0]       magnitude_sum,
  output logic [SUM_W-1:0]       weight_sum,
  output logic                   frame_end
);

  localparam int PIX_W = $clog2(MAX_LINE_LENGTH);

  // Configuration registers.
  logic [MAG_W-1:0] magnitude_threshold;
  logic [LEN_W-1:0] line_length;
  logic [LEN_W-1:0] line_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude_threshold <= '0;
      line_length         <= LEN_W'(1024);
      line_count          <= LEN_W'(1024);
    end else if (config_write) begin
      unique case (config_index)
        CFG_THRESHOLD:   magnitude_threshold <= config_data[MAG_W-1:0];
        CFG_LINE_LENGTH: line_length         <= config_data[LEN_W-1:0];
        CFG_LINE_COUNT:  line_count          <= config_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake. The output register moves when it is empty or taken, and
  // the input stage moves when it is empty or can pass its pixel on.
  logic s1_valid;
  logic out_ready, s1_ready, accept, s1_advance;

  assign out_ready   = !sum_valid || !sum_stall;
  assign s1_ready    = !s1_valid || out_ready;
  assign pixel_stall = !s1_ready;
  assign accept      = pixel_valid && s1_ready;
  assign s1_advance  = s1_valid && out_ready;

  // Scan position of the pixel being offered.
  logic [PIX_W-1:0] scan_col;
  scan_info_t       scan_info;

  dii_scan #(
    .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
    .MAX_LINE_COUNT  (MAX_LINE_COUNT)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .line_length (line_length),
    .line_count  (line_count),
    .col         (scan_col),
    .info        (scan_info)
  );

  // Running sums of the current line. The first line and first column
  // contribute nothing, and each line restarts from zero.
  logic [SUM_W-1:0] magnitude_run, weight_run;
  logic [SUM_W-1:0] mag_contrib, wgt_contrib;
  logic [SUM_W-1:0] mag_run_next, wgt_run_next;

  always_comb begin
    if (scan_info.first_col || scan_info.first_line) begin
      mag_contrib = '0;
      wgt_contrib = '0;
    end else begin
      mag_contrib = (edge_magnitude > magnitude_threshold) ? SUM_W'(edge_magnitude) : '0;
      wgt_contrib = SUM_W'(point_weight);
    end
    mag_run_next = sat_add(scan_info.first_col ? '0 : magnitude_run, mag_contrib);
    wgt_run_next = sat_add(scan_info.first_col ? '0 : weight_run, wgt_contrib);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude_run <= '0;
      weight_run    <= '0;
    end else if (accept) begin
      magnitude_run <= scan_info.last_pix ? '0 : mag_run_next;
      weight_run    <= scan_info.last_pix ? '0 : wgt_run_next;
    end
  end

  // Input stage registers; the line buffers register their read data on
  // the same edge.
  logic [SUM_W-1:0] s1_mag_run, s1_wgt_run;
  logic [PIX_W-1:0] s1_col;
  logic             s1_first_line, s1_frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mag_run    <= mag_run_next;
      s1_wgt_run    <= wgt_run_next;
      s1_col        <= scan_col;
      s1_first_line <= scan_info.first_line;
      s1_frame_end  <= scan_info.frame_end;
    end
  end

  // Line buffers and the add of the integral from the line above.
  logic [SUM_W-1:0] mag_above_rd, wgt_above_rd;
  logic [SUM_W-1:0] mag_sum_next, wgt_sum_next;

  always_comb begin
    mag_sum_next = sat_add(s1_mag_run, s1_first_line ? '0 : mag_above_rd);
    wgt_sum_next = sat_add(s1_wgt_run, s1_first_line ? '0 : wgt_above_rd);
  end

  dii_line_buf #(
    .DEPTH (MAX_LINE_LENGTH)
  ) u_mag_line (
    .clk          (clk),
    .read_enable  (accept),
    .read_addr    (scan_col),
    .read_data    (mag_above_rd),
    .write_enable (s1_advance),
    .write_addr   (s1_col),
    .write_data   (mag_sum_next)
  );

  dii_line_buf #(
    .DEPTH (MAX_LINE_LENGTH)
  ) u_wgt_line (
    .clk          (clk),
    .read_enable  (accept),
    .read_addr    (scan_col),
    .read_data    (wgt_above_rd),
    .write_enable (s1_advance),
    .write_addr   (s1_col),
    .write_data   (wgt_sum_next)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (out_ready) begin
      sum_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      magnitude_sum <= mag_sum_next;
      weight_sum    <= wgt_sum_next;
      frame_end     <= s1_frame_end;
    end
  end

  // Assertions.
`include "dual_integral_image_assert.svh"

  `DII_ASSERT_NEXT(a_accept_fills_stage, clk, rst, accept, s1_valid)
  `DII_ASSERT_SAME(a_stall_only_when_full, clk, rst, pixel_stall, s1_valid && sum_valid)
  `DII_ASSERT_NEXT(a_frame_end_wraps_col, clk, rst, accept && scan_info.frame_end, scan_col == '0)
  `DII_ASSERT_NEXT(a_run_never_drops, clk, rst, accept && !scan_info.first_col,
                   s1_mag_run >= $past(magnitude_run))

endmodule

// ===== rtl/dii_scan.sv =====
// ---------------------------------------------------------------------------
// Raster scan counters
// Tracks pixel and line position and flags line and frame boundaries.
// ---------------------------------------------------------------------------
module dii_scan import dii_pkg::*; #(
  parameter int MAX_LINE_LENGTH = MAX_LINE_LENGTH_DEFAULT,
  parameter int MAX_LINE_COUNT  = MAX_LINE_COUNT_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  logic [LEN_W-1:0]                   line_length,
  input  logic [LEN_W-1:0]                   line_count,
  output logic [$clog2(MAX_LINE_LENGTH)-1:0] col,
  output scan_info_t                         info
);

  localparam int PIX_W = $clog2(MAX_LINE_LENGTH);
  localparam int LIN_W = $clog2(MAX_LINE_COUNT);
  localparam int PCMP_W = (PIX_W + 1 > LEN_W) ? PIX_W + 1 : LEN_W;
  localparam int LCMP_W = (LIN_W + 1 > LEN_W) ? LIN_W + 1 : LEN_W;

  logic [PIX_W-1:0]  pixel_position;
  logic [LIN_W-1:0]  line_position;
  logic [PCMP_W-1:0] len_raw, len_eff, pix_inc;
  logic [LCMP_W-1:0] cnt_raw, cnt_eff, line_inc;

  always_comb begin
    len_raw = PCMP_W'(line_length);
    cnt_raw = LCMP_W'(line_count);
    if (len_raw < PCMP_W'(LEN_MIN)) len_eff = PCMP_W'(LEN_MIN);
    else if (len_raw > PCMP_W'(MAX_LINE_LENGTH)) len_eff = PCMP_W'(MAX_LINE_LENGTH);
    else len_eff = len_raw;
    if (cnt_raw < LCMP_W'(LEN_MIN)) cnt_eff = LCMP_W'(LEN_MIN);
    else if (cnt_raw > LCMP_W'(MAX_LINE_COUNT)) cnt_eff = LCMP_W'(MAX_LINE_COUNT);
    else cnt_eff = cnt_raw;
    pix_inc  = PCMP_W'(pixel_position) + PCMP_W'(1);
    line_inc = LCMP_W'(line_position) + LCMP_W'(1);
    info.first_col  = (pixel_position == '0);
    info.first_line = (line_position == '0);
    info.last_pix   = (pix_inc >= len_eff);
    info.frame_end  = info.last_pix && (line_inc >= cnt_eff);
  end

  assign col = pixel_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
      line_position  <= '0;
    end else if (advance) begin
      if (info.last_pix) begin
        pixel_position <= '0;
        line_position  <= info.frame_end ? '0 : LIN_W'(line_inc);
      end else begin
        pixel_position <= PIX_W'(pix_inc);
      end
    end
  end

endmodule

// ===== rtl/dii_line_buf.sv =====
// ---------------------------------------------------------------------------
// Line buffer
// One-write, one-read memory holding the previous line's integrals.
// ---------------------------------------------------------------------------
module dii_line_buf import dii_pkg::*; #(
  parameter int DEPTH = MAX_LINE_LENGTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     read_enable,
  input  logic [$clog2(DEPTH)-1:0] read_addr,
  output logic [SUM_W-1:0]         read_data,
  input  logic                     write_enable,
  input  logic [$clog2(DEPTH)-1:0] write_addr,
  input  logic [SUM_W-1:0]         write_data
);

  logic [SUM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (write_enable) begin
      mem[write_addr] <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (read_enable) begin
      read_data <= mem[read_addr];
    end
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Dual integral image testbench
// Streams raster-ordered pixels into the block and predicts both summed-area
// tables in the testbench. The predictor covers thresholding, saturation,
// clamped scan sizes and register updates inside a frame. Every result
// transfer is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb import dii_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // The block ignores writes to the fourth register slot. The run still
  // writes it so that every index value reaches the port.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  localparam int CYCLE_LIMIT    = 250000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int HOLD_CYCLES    = 64;
  localparam int MAX_GAP        = 11;
  localparam int RANDOM_PIXELS  = 220;
  localparam int MISMATCH_PRINT = 100;

  // One predicted result transfer.
  typedef struct packed {
    logic [SUM_W-1:0] magnitude_sum;
    logic [SUM_W-1:0] weight_sum;
    logic             frame_end;
  } sums_t;

  // Clock, reset and the block's inputs, all known from time zero.
  logic                   clk            = 1'b0;
  logic                   rst            = 1'b1;
  logic                   config_write   = 1'b0;
  logic [CFG_INDEX_W-1:0] config_index   = CFG_THRESHOLD;
  logic [CFG_DATA_W-1:0]  config_data    = '0;
  logic                   pixel_valid    = 1'b0;
  logic [MAG_W-1:0]       edge_magnitude = '0;
  logic [WGT_W-1:0]       point_weight   = '0;
  logic                   sum_stall      = 1'b0;

  logic                   pixel_stall;
  logic                   sum_valid;
  logic [SUM_W-1:0]       magnitude_sum;
  logic [SUM_W-1:0]       weight_sum;
  logic                   frame_end;

  dual_integral_image dut (
    .clk            (clk),
    .rst            (rst),
    .config_write   (config_write),
    .config_index   (config_index),
    .config_data    (config_data),
    .pixel_valid    (pixel_valid),
    .pixel_stall    (pixel_stall),
    .edge_magnitude (edge_magnitude),
    .point_weight   (point_weight),
    .sum_valid      (sum_valid),
    .sum_stall      (sum_stall),
    .magnitude_sum  (magnitude_sum),
    .weight_sum     (weight_sum),
    .frame_end      (frame_end)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the registers, the two line buffers,
  // the running line sums and the scan counters, at the block's widths.
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0] threshold_reg = '0;
  logic [LEN_W-1:0] length_reg    = LEN_W'(MAX_LINE_LENGTH_DEFAULT);
  logic [LEN_W-1:0] count_reg     = LEN_W'(MAX_LINE_COUNT_DEFAULT);
  logic [SUM_W-1:0] mag_above [MAX_LINE_LENGTH_DEFAULT];
  logic [SUM_W-1:0] wgt_above [MAX_LINE_LENGTH_DEFAULT];
  bit               line_written [MAX_LINE_LENGTH_DEFAULT];
  logic [SUM_W-1:0] mag_run = '0;
  logic [SUM_W-1:0] wgt_run = '0;
  logic [9:0]       scan_col = '0;
  logic [9:0]       scan_row = '0;

  // Predicted results waiting for their transfer, oldest first.
  sums_t pending_sums [$];

  // Idling controls. Each side draws a fresh wait per item while its flag is
  // set; clearing a flag gives a stretch at full rate.
  bit sender_gaps     = 1'b0;
  bit receiver_stalls = 1'b0;
  int stall_left      = 0;

  // A long receiver hold-off is requested by toggling hold_token; the hold
  // process counts the stretch down on its own.
  bit hold_token = 1'b0;
  bit hold_seen  = 1'b0;
  int hold_left  = 0;

  // Run statistics.
  int cycle_count    = 0;
  int pixels_sent    = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int frames_closed  = 0;
  int saturated_sums = 0;
  int inframe_writes = 0;

  // Saturating 36-bit addition used by the predictor.
  function automatic logic [SUM_W-1:0] clip_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
    logic [SUM_W:0] total;
    total = a + b;
    return (total > {1'b0, SUM_MAX}) ? SUM_MAX : total[SUM_W-1:0];
  endfunction

  // Scan sizes outside the legal range are pulled back to its nearest end.
  function automatic int unsigned clamp_size(input logic [LEN_W-1:0] raw,
                                             input int unsigned most);
    if (raw < LEN_MIN) return LEN_MIN;
    if (raw > most) return most;
    return 32'(raw);
  endfunction

  // Advances the predictor by one pixel and returns the sums it should cause.
  function automatic sums_t integral_step(input logic [MAG_W-1:0] mag,
                                          input logic [WGT_W-1:0] wgt);
    sums_t            result;
    logic [SUM_W-1:0] mag_add, wgt_add, mag_up, wgt_up;
    int unsigned      row_len, rows;
    logic             line_done, frame_done;
    row_len = clamp_size(length_reg, MAX_LINE_LENGTH_DEFAULT);
    rows    = clamp_size(count_reg, MAX_LINE_COUNT_DEFAULT);
    // The first line and the first column are the zero border of the table.
    if (scan_col == 0 || scan_row == 0) begin
      mag_add = '0;
      wgt_add = '0;
    end else begin
      mag_add = (mag > threshold_reg) ? SUM_W'(mag) : '0;
      wgt_add = SUM_W'(wgt);
    end
    if (scan_col == 0) begin
      mag_run = '0;
      wgt_run = '0;
    end
    mag_run = clip_add(mag_run, mag_add);
    wgt_run = clip_add(wgt_run, wgt_add);
    // The line buffers are not consulted on the first line of a frame.
    if (scan_row == 0) begin
      mag_up = '0;
      wgt_up = '0;
    end else begin
      mag_up = mag_above[scan_col];
      wgt_up = wgt_above[scan_col];
    end
    result.magnitude_sum = clip_add(mag_run, mag_up);
    result.weight_sum    = clip_add(wgt_run, wgt_up);
    mag_above[scan_col]    = result.magnitude_sum;
    wgt_above[scan_col]    = result.weight_sum;
    line_written[scan_col] = 1'b1;
    // A counter at or past a lowered size still ends its line or frame.
    line_done  = (scan_col + 1 >= row_len);
    frame_done = line_done && (scan_row + 1 >= rows);
    if (line_done) begin
      scan_col = '0;
      mag_run  = '0;
      wgt_run  = '0;
      scan_row = frame_done ? 10'd0 : scan_row + 10'd1;
    end else begin
      scan_col = scan_col + 10'd1;
    end
    result.frame_end = frame_done;
    if (frame_done) frames_closed++;
    if (result.weight_sum == SUM_MAX) saturated_sums++;
    return result;
  endfunction

  function automatic void take_register(input logic [CFG_INDEX_W-1:0] slot,
                                        input logic [CFG_DATA_W-1:0] value);
    case (slot)
      CFG_THRESHOLD:   threshold_reg = value[MAG_W-1:0];
      CFG_LINE_LENGTH: length_reg    = value[LEN_W-1:0];
      CFG_LINE_COUNT:  count_reg     = value[LEN_W-1:0];
      default: ;
    endcase
  endfunction

  // A new line length is safe when no line buffer entry that was never
  // written can be read under it. The first line of a frame reads nothing.
  function automatic bit length_safe(input logic [CFG_DATA_W-1:0] raw);
    int unsigned span;
    span = clamp_size(raw[LEN_W-1:0], MAX_LINE_LENGTH_DEFAULT);
    if (scan_row == 0) return 1'b1;
    for (int c = 0; c < span; c++) begin
      if (!line_written[c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Magnitudes favor the extremes and the values around the threshold, since
  // the strict comparison is where the thresholding can go wrong.
  function automatic logic [MAG_W-1:0] random_magnitude();
    int pick, near;
    pick = $urandom_range(0, 9);
    near = int'(threshold_reg) - 1 + int'($urandom_range(0, 2));
    if (near < 0) near = 0;
    if (near > 65535) near = 65535;
    case (pick)
      0:       return '0;
      1:       return '1;
      2, 3, 4: return MAG_W'(near);
      default: return MAG_W'($urandom);
    endcase
  endfunction

  // Point weights are mostly zero, as only anchor pixels carry one.
  function automatic logic [WGT_W-1:0] random_weight();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3, 4: return '0;
      5:             return '1;
      6:             return WGT_W'(1) << $urandom_range(0, WGT_W - 1);
      default:       return WGT_W'($urandom);
    endcase
  endfunction

  // Mostly small scan sizes, now and then a clamped or a somewhat larger one.
  // The unused upper data bits are random and must be ignored.
  function automatic logic [CFG_DATA_W-1:0] random_size(input int unsigned top);
    logic [LEN_W-1:0] raw;
    int               pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) raw = LEN_W'($urandom_range(0, 1));
    else if (pick == 1) raw = LEN_W'($urandom_range(13, 40));
    else raw = LEN_W'($urandom_range(2, top));
    return {(CFG_DATA_W - LEN_W)'($urandom), raw};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_threshold();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return CFG_DATA_W'($urandom);
  endfunction

  task automatic report_mismatch(input string what, input logic [SUM_W-1:0] want,
                                 input logic [SUM_W-1:0] got);
    mismatches++;
    if (mismatches <= MISMATCH_PRINT)
      $display("mismatch on %s at result %0d: expected %h, got %h",
               what, results_seen, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Sender side. send_pixel leaves pixel_valid high after its transfer, so a
  // following pixel with no gap keeps the channel busy without a bubble. Any
  // task that stops sending lowers valid through drain.
  // --------------------------------------------------------------------------
  task automatic send_pixel(input logic [MAG_W-1:0] mag, input logic [WGT_W-1:0] wgt);
    int gap;
    gap = sender_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid    <= 1'b1;
    edge_magnitude <= mag;
    point_weight   <= wgt;
    // Values read right after the edge are the ones the block sampled.
    do @(posedge clk); while (pixel_stall);
    pending_sums = {pending_sums, integral_step(mag, wgt)};
    pixels_sent++;
  endtask

  // Stops sending and waits until every predicted result has been taken,
  // then lets the pipeline settle.
  task automatic drain();
    pixel_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sends filler pixels until the scan is back at the top of a frame.
  task automatic finish_frame();
    while (scan_col != 0 || scan_row != 0) send_pixel(random_magnitude(), random_weight());
  endtask

  // Writes all registers, plus the ignored slot, with the block idle. A
  // length that could expose unwritten buffer entries waits for a new frame.
  task automatic write_registers(input logic [CFG_DATA_W-1:0] thr,
                                 input logic [CFG_DATA_W-1:0] len,
                                 input logic [CFG_DATA_W-1:0] cnt);
    logic [CFG_INDEX_W-1:0] slot [4];
    logic [CFG_DATA_W-1:0]  value [4];
    if (!length_safe(len)) finish_frame();
    drain();
    if (scan_col != 0 || scan_row != 0) inframe_writes++;
    slot  = '{CFG_THRESHOLD, CFG_LINE_LENGTH, CFG_LINE_COUNT, CFG_SPARE};
    value = '{thr, len, cnt, CFG_DATA_W'($urandom)};
    for (int i = 0; i < 4; i++) begin
      config_write <= 1'b1;
      config_index <= slot[i];
      config_data  <= value[i];
      @(posedge clk);
      take_register(slot[i], value[i]);
    end
    config_write <= 1'b0;
  endtask

  // Starts a long receiver hold-off without waiting on the clock.
  task automatic hold_receiver();
    hold_token <= ~hold_token;
  endtask

  // --------------------------------------------------------------------------
  // Receiver side. A transfer is taken at an edge where sum_valid is high and
  // sum_stall is low; each one is checked against the oldest prediction and
  // then a fresh stall length is drawn for the next result.
  // --------------------------------------------------------------------------
  task automatic check_sums();
    sums_t want;
    if (pending_sums.size() == 0) begin
      report_mismatch("result with no pixel pending", '0, magnitude_sum);
    end else begin
      want = pending_sums.pop_front();
      if (magnitude_sum !== want.magnitude_sum)
        report_mismatch("magnitude_sum", want.magnitude_sum, magnitude_sum);
      if (weight_sum !== want.weight_sum)
        report_mismatch("weight_sum", want.weight_sum, weight_sum);
      if (frame_end !== want.frame_end)
        report_mismatch("frame_end", SUM_W'(want.frame_end), SUM_W'(frame_end));
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sum_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (sum_valid && !sum_stall) begin
        check_sums();
        stall_left = receiver_stalls ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (hold_left > 0) begin
        sum_stall <= 1'b1;
      end else if (stall_left > 0) begin
        sum_stall <= 1'b1;
        stall_left--;
      end else begin
        sum_stall <= 1'b0;
      end
    end
  end

  // The long hold-off is counted here, apart from the per-result stalls.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog: a run that hangs on a handshake ends here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d results pending",
             cycle_count, pending_sums.size());
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset configuration: the pixels land on the first line of the frame, so
  // every sum is zero whatever the inputs.
  task automatic test_reset_defaults();
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    send_pixel('1, '1);
    send_pixel('0, '0);
    send_pixel(16'h0001, 24'h000001);
  endtask

  // Smallest frame, reached through clamping of raw sizes zero and one.
  // Lowering the length mid-line also ends the line left over from the
  // reset test. Only the pixel at line one, column one counts, and a
  // magnitude equal to the threshold must count as zero.
  task automatic test_minimum_frame();
    write_registers(16'h8000, 16'hF800, 16'h0001);
    finish_frame();
    repeat (3) send_pixel('1, '1);
    send_pixel(16'h8001, 24'hFFFFFF);
    repeat (3) send_pixel('0, '0);
    send_pixel(16'h8000, 24'h800000);
  endtask

  // Threshold at both ends: zero lets every nonzero magnitude through, the
  // top value lets none through.
  task automatic test_threshold_extremes();
    write_registers(16'h0000, 16'h0003, 16'h0002);
    finish_frame();
    repeat (3) send_pixel('1, 24'h5A5A5A);
    send_pixel('1, 24'hA5A5A5);
    send_pixel(16'h0000, 24'h000001);
    send_pixel(16'h0001, 24'hFFFFFE);
    write_registers(16'hFFFF, 16'h0003, 16'h0002);
    repeat (3) send_pixel(16'h1234, 24'h0F0F0F);
    send_pixel('1, '1);
    send_pixel('1, 24'hF0F0F0);
    send_pixel(16'hFFFE, 24'h00FF00);
  endtask

  // Sizes lowered below the current counters end the line or the frame at
  // once; raising the length again inside the frame reads stale entries.
  task automatic test_counter_beyond();
    write_registers(16'h1234, 16'h0008, 16'h0004);
    finish_frame();
    repeat (13) send_pixel(random_magnitude(), random_weight());
    write_registers(16'h1234, 16'h0003, 16'h0004);
    repeat (4) send_pixel(random_magnitude(), random_weight());
    write_registers(16'h1234, 16'h0008, 16'h0002);
    repeat (8) send_pixel(random_magnitude(), random_weight());
  endtask

  // A frame of 40-pixel lines with top weights at full rate carries large
  // values through both sums and the line buffers. It also writes every
  // buffer column that the random sizes can reach. Saturating a sum would
  // take a frame of several thousand pixels, so it is left to the predictor.
  task automatic test_top_weights();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    write_registers(16'h0000, 16'hF828, 16'h0003);
    finish_frame();
    repeat (3 * 40) send_pixel(MAG_W'($urandom), '1);
  endtask

  // Tall frame: a line count beyond the range clamps to the maximum, so no
  // frame_end may appear over the first lines of two pixels each.
  task automatic test_tallest_frame();
    write_registers(16'h00FF, 16'h0002, 16'hFFFF);
    finish_frame();
    repeat (40) send_pixel(random_magnitude(), random_weight());
  endtask

  // The receiver holds off for a long stretch while pixels keep coming, so
  // the pipeline fills and pixel_stall must rise. The sender then pauses
  // until every result has come out.
  task automatic test_backpressure();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    write_registers(16'h4000, 16'h0005, 16'h0004);
    hold_receiver();
    repeat (40) send_pixel(random_magnitude(), random_weight());
    drain();
    receiver_stalls = 1'b1;
    hold_receiver();
    repeat (40) send_pixel(random_magnitude(), random_weight());
    drain();
  endtask

  // Random phases: each picks an idling mode and a configuration, then
  // streams a random number of pixels. Phases do not line up with frames,
  // so many register updates land inside a frame.
  task automatic test_random_frames();
    int first, count, mode;
    first = pixels_sent;
    while (pixels_sent - first < RANDOM_PIXELS) begin
      mode = $urandom_range(0, 3);
      sender_gaps     = mode[0];
      receiver_stalls = mode[1];
      write_registers(random_threshold(), random_size(12), random_size(8));
      count = $urandom_range(5, 60);
      if ($urandom_range(0, 5) == 0) hold_receiver();
      repeat (count) send_pixel(random_magnitude(), random_weight());
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_minimum_frame();
    test_threshold_extremes();
    test_counter_beyond();
    test_top_weights();
    test_tallest_frame();
    test_backpressure();
    test_random_frames();
    drain();
    if (pending_sums.size() != 0)
      report_mismatch("results never delivered", SUM_W'(pending_sums.size()), '0);
    $display("covered %0d pixel transfers over %0d complete frames, %0d saturated weight sums",
             pixels_sent, frames_closed, saturated_sums);
    $display("%0d register updates inside a frame, %0d results checked in %0d cycles",
             inframe_writes, results_seen, cycle_count);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dii_pkg.sv
rtl/dii_scan.sv
rtl/dii_line_buf.sv
rtl/dual_integral_image.sv
sim/tb.sv
